@@ hw/rtl/bfsa_pkg.sv @@
package bfsa_pkg;
	localparam int FREE_SLOTS  = 16;
	localparam int USED_SLOTS  = 16;
	localparam int JOB_ID_BITS = 8;
	localparam int ADDR_BITS   = 16;
	localparam int LEN_BITS    = ADDR_BITS + 1;
	localparam int FIDX_BITS   = $clog2(FREE_SLOTS);
	localparam int UIDX_BITS   = $clog2(USED_SLOTS);
	localparam int FCNT_BITS   = $clog2(FREE_SLOTS + 1);

	typedef enum logic [2:0] {
		ST_ALLOC   = 3'd0,
		ST_RECLAIM = 3'd1,
		ST_DUP     = 3'd2,
		ST_EMPTY   = 3'd3,
		ST_SMALL   = 3'd4,
		ST_UNKNOWN = 3'd5,
		ST_FULL    = 3'd6
	} status_t;

	typedef enum logic [0:0] {
		CFG_BASE = 1'b0,
		CFG_SIZE = 1'b1
	} cfg_idx_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_DECIDE,
		S_APPLY,
		S_OUT
	} fsm_t;

	// free-segment cell commands
	typedef enum logic [2:0] {
		FC_HOLD,
		FC_INIT,
		FC_SHIFT_DOWN,
		FC_SHIFT_UP,
		FC_LOAD,
		FC_MERGE
	} fcmd_t;

	typedef struct packed {
		logic [ADDR_BITS-1:0] start;
		logic [LEN_BITS-1:0]  len;
	} seg_t;

	typedef struct packed {
		fcmd_t                cmd;
		logic [FIDX_BITS-1:0] pos;   // target cell of a load, shift or merge
		seg_t                 seg;   // data loaded into the target cell
		seg_t                 init;  // region segment for init
		logic                 init_ok;
	} fctl_t;
endpackage

@@ hw/rtl/bfsa_if.sv @@
interface bfsa_req_if;
	import bfsa_pkg::*;
	logic                   valid;
	logic                   ready;
	logic                   mode;
	logic [JOB_ID_BITS-1:0] job_id;
	logic [LEN_BITS-1:0]    job_len;
	modport source (output valid, mode, job_id, job_len, input ready);
	modport sink   (input valid, mode, job_id, job_len, output ready);
endinterface

interface bfsa_rsp_if;
	import bfsa_pkg::*;
	logic                 valid;
	logic                 ready;
	logic [2:0]           status;
	logic [ADDR_BITS-1:0] seg_base;
	logic [LEN_BITS-1:0]  seg_len;
	modport source (output valid, status, seg_base, seg_len, input ready);
	modport sink   (input valid, status, seg_base, seg_len, output ready);
endinterface

@@ hw/rtl/best_fit_segment_allocator.sv @@
// channel | dir | payload
// req     | in  | mode, job_id, job_len
// rsp     | out | status, seg_base, seg_len
// cfg     | in  | cfg_we, cfg_idx, cfg_data
// a new request is only accepted once the previous response has been taken
// one scan cycle per table entry, used table first, then decide, apply, output and idle
// the free table is a row of cells that shift as one on insert or removal
// reset and any config write give one free segment covering the clipped region (none if empty), req held meanwhile
// rsp holds in its output register until taken; req stalls meanwhile
module best_fit_segment_allocator
	import bfsa_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic                  cfg_idx,
	input  logic [LEN_BITS-1:0]   cfg_data,
	bfsa_req_if.sink              req,
	bfsa_rsp_if.source            rsp
);
	localparam int SCAN_N = FREE_SLOTS + USED_SLOTS;
	localparam int SC_BITS = $clog2(SCAN_N + 1);

	logic [ADDR_BITS-1:0] base_q;
	logic [LEN_BITS-1:0]  size_q;
	logic                 init_q;
	fsm_t state_q, state_d;

	logic                   mode_q;
	logic [JOB_ID_BITS-1:0] id_q;
	logic [LEN_BITS-1:0]    len_q;
	logic [SC_BITS-1:0]     cnt_q;
	logic [FCNT_BITS-1:0]   fcnt_q, fcnt_d;

	logic [USED_SLOTS-1:0]  uvalid_q, uvalid_d;
	logic [JOB_ID_BITS-1:0] uown_q [USED_SLOTS];
	seg_t                   useg_q [USED_SLOTS];

	// scan results
	logic                 hit_q, slot_ok_q, pick_ok_q;
	logic [UIDX_BITS-1:0] hit_idx_q, slot_q;
	logic [FIDX_BITS-1:0] pick_q;
	seg_t                 pick_seg_q;
	logic [FCNT_BITS-1:0] pos_q;
	seg_t                 job_seg_q;
	seg_t                 low_q, high_q;
	logic                 low_ok_q, high_ok_q;

	status_t              st_q, status_d;
	seg_t                 res_q, res_d;
	fctl_t                fctl_q, fctl_d;
	logic                 rvalid_q;

	seg_t cells [FREE_SLOTS];

	genvar g;
	generate
		for (g = 0; g < FREE_SLOTS; g++) begin : g_cell
			bfsa_free_cell u_cell (
				.clk       (clk),
				.arst_n    (arst_n),
				.idx       (FIDX_BITS'(g)),
				.ctl       (fctl_q),
				.from_above((g == FREE_SLOTS - 1) ? seg_t'('0) : cells[(g + 1) % FREE_SLOTS]),
				.from_below((g == 0) ? seg_t'('0) : cells[(g + FREE_SLOTS - 1) % FREE_SLOTS]),
				.seg       (cells[g])
			);
		end
	endgenerate

	// clipped region size
	logic [LEN_BITS-1:0] limit, clip;
	assign limit = LEN_BITS'(1) << ADDR_BITS;
	always_comb begin
		clip = size_q;
		if (size_q > limit - LEN_BITS'(base_q)) clip = limit - LEN_BITS'(base_q);
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE:   if (req.valid && req.ready) state_d = S_SCAN;
			S_SCAN:   if (cnt_q == SC_BITS'(SCAN_N - 1)) state_d = S_DECIDE;
			S_DECIDE: state_d = S_APPLY;
			S_APPLY:  state_d = S_OUT;
			S_OUT:    if (rsp.ready) state_d = S_IDLE;
			default:  state_d = S_IDLE;
		endcase
	end

	always_comb begin
		req.ready = (state_q == S_IDLE) && !init_q && !cfg_we;
		rsp.valid = rvalid_q;
	end
	assign rsp.status   = st_q;
	assign rsp.seg_base = res_q.start;
	assign rsp.seg_len  = res_q.len;

	// scan indexes: used table first, then free cells
	logic                 in_used;
	logic [FIDX_BITS-1:0] fi;
	logic [UIDX_BITS-1:0] ui;
	seg_t                 fc;
	assign in_used = cnt_q < SC_BITS'(USED_SLOTS);
	assign ui = cnt_q[UIDX_BITS-1:0];
	assign fi = FIDX_BITS'(cnt_q - SC_BITS'(USED_SLOTS));
	assign fc = cells[fi];

	// decision
	logic join_lo, join_hi, alloc_go, rec_go;
	assign join_lo = low_ok_q &&
	                 (LEN_BITS'(low_q.start) + low_q.len) == LEN_BITS'(job_seg_q.start);
	assign join_hi = high_ok_q &&
	                 LEN_BITS'(high_q.start) == LEN_BITS'(job_seg_q.start) + job_seg_q.len;
	assign alloc_go = !mode_q && !hit_q && fcnt_q != '0 && len_q != '0 && pick_ok_q
	                  && slot_ok_q;
	assign rec_go = mode_q && hit_q &&
	                (join_lo || join_hi || fcnt_q < FCNT_BITS'(FREE_SLOTS));

	always_comb begin
		if (!mode_q) begin
			priority if (hit_q) status_d = ST_DUP;
			else if (fcnt_q == '0) status_d = ST_EMPTY;
			else if (len_q == '0 || !pick_ok_q) status_d = ST_SMALL;
			else if (!slot_ok_q) status_d = ST_FULL;
			else status_d = ST_ALLOC;
		end else begin
			priority if (!hit_q) status_d = ST_UNKNOWN;
			else if (!rec_go) status_d = ST_FULL;
			else status_d = ST_RECLAIM;
		end
	end

	always_comb begin
		res_d = '0;
		if (alloc_go) res_d = '{start: pick_seg_q.start, len: len_q};
		else if (rec_go) res_d = job_seg_q;
	end

	// cell commands and table updates
	always_comb begin
		fctl_d     = fctl_q;
		fctl_d.cmd = FC_HOLD;
		fcnt_d     = fcnt_q;
		uvalid_d   = uvalid_q;
		if (init_q && !cfg_we) begin
			fctl_d.cmd     = FC_INIT;
			fctl_d.init    = '{start: base_q, len: clip};
			fctl_d.init_ok = clip != '0;
			fcnt_d         = (clip != '0) ? FCNT_BITS'(1) : '0;
			uvalid_d       = '0;
		end else if (state_q == S_DECIDE) begin
			if (alloc_go) begin
				uvalid_d[slot_q] = 1'b1;
				fctl_d.pos       = pick_q;
				if (pick_seg_q.len == len_q) begin
					fctl_d.cmd = FC_SHIFT_DOWN;
					fcnt_d     = fcnt_q - FCNT_BITS'(1);
				end else begin
					fctl_d.cmd = FC_LOAD;
					fctl_d.seg = '{start: ADDR_BITS'(LEN_BITS'(pick_seg_q.start) + len_q),
					               len: pick_seg_q.len - len_q};
				end
			end else if (rec_go) begin
				uvalid_d[hit_idx_q] = 1'b0;
				if (join_lo && join_hi) begin
					fctl_d.cmd = FC_MERGE;
					fctl_d.pos = FIDX_BITS'(pos_q);
					fctl_d.seg = '{start: low_q.start,
					               len: low_q.len + job_seg_q.len + high_q.len};
					fcnt_d     = fcnt_q - FCNT_BITS'(1);
				end else if (join_lo) begin
					fctl_d.cmd = FC_LOAD;
					fctl_d.pos = FIDX_BITS'(pos_q - FCNT_BITS'(1));
					fctl_d.seg = '{start: low_q.start, len: low_q.len + job_seg_q.len};
				end else if (join_hi) begin
					fctl_d.cmd = FC_LOAD;
					fctl_d.pos = FIDX_BITS'(pos_q);
					fctl_d.seg = '{start: job_seg_q.start, len: job_seg_q.len + high_q.len};
				end else begin
					fctl_d.cmd = FC_SHIFT_UP;
					fctl_d.pos = FIDX_BITS'(pos_q);
					fctl_d.seg = job_seg_q;
					fcnt_d     = fcnt_q + FCNT_BITS'(1);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			base_q   <= '0;
			size_q   <= LEN_BITS'(16);
			init_q   <= 1'b1;
			uvalid_q <= '0;
			fcnt_q   <= '0;
			rvalid_q <= 1'b0;
			fctl_q   <= '0;
			st_q     <= ST_ALLOC;
			res_q    <= '0;
		end else begin
			state_q  <= state_d;
			fctl_q   <= fctl_d;
			fcnt_q   <= fcnt_d;
			uvalid_q <= uvalid_d;
			init_q   <= cfg_we;
			if (cfg_we) begin
				if (cfg_idx == CFG_BASE) base_q <= cfg_data[ADDR_BITS-1:0];
				else size_q <= cfg_data;
			end
			if (state_q == S_APPLY) rvalid_q <= 1'b1;
			else if (rvalid_q && rsp.ready) rvalid_q <= 1'b0;
			if (state_q == S_DECIDE) begin
				st_q  <= status_d;
				res_q <= res_d;
			end
		end
	end

	// request capture and table scan, one entry per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= 1'b0;
			id_q       <= '0;
			len_q      <= '0;
			cnt_q      <= '0;
			hit_q      <= 1'b0;
			hit_idx_q  <= '0;
			job_seg_q  <= '0;
			slot_ok_q  <= 1'b0;
			slot_q     <= '0;
			pick_ok_q  <= 1'b0;
			pick_q     <= '0;
			pick_seg_q <= '0;
			pos_q      <= '0;
			low_q      <= '0;
			low_ok_q   <= 1'b0;
			high_q     <= '0;
			high_ok_q  <= 1'b0;
		end else if (req.valid && req.ready) begin
			mode_q     <= req.mode;
			id_q       <= req.job_id;
			len_q      <= req.job_len;
			cnt_q      <= '0;
			hit_q      <= 1'b0;
			slot_ok_q  <= 1'b0;
			pick_ok_q  <= 1'b0;
			pos_q      <= '0;
			low_ok_q   <= 1'b0;
			high_ok_q  <= 1'b0;
		end else if (state_q == S_SCAN) begin
			cnt_q <= cnt_q + SC_BITS'(1);
			if (in_used) begin
				if (uvalid_q[ui] && uown_q[ui] == id_q && !hit_q) begin
					hit_q     <= 1'b1;
					hit_idx_q <= ui;
					job_seg_q <= useg_q[ui];
				end
				if (!uvalid_q[ui] && !slot_ok_q) begin
					slot_ok_q <= 1'b1;
					slot_q    <= ui;
				end
			end else if (FCNT_BITS'(fi) < fcnt_q) begin
				if (fc.len >= len_q && (!pick_ok_q || fc.len < pick_seg_q.len)) begin
					pick_ok_q  <= 1'b1;
					pick_q     <= fi;
					pick_seg_q <= fc;
				end
				// table is address sorted: last start below the job is the lower neighbour
				if (fc.start < job_seg_q.start) begin
					pos_q    <= FCNT_BITS'(fi) + FCNT_BITS'(1);
					low_q    <= fc;
					low_ok_q <= 1'b1;
				end else if (!high_ok_q) begin
					high_q    <= fc;
					high_ok_q <= 1'b1;
				end
			end
		end
	end

	// job table contents, only read where the valid bit is set
	always_ff @(posedge clk) begin
		if (state_q == S_DECIDE && alloc_go) begin
			uown_q[slot_q] <= id_q;
			useg_q[slot_q] <= '{start: pick_seg_q.start, len: len_q};
		end
	end

	`ifndef SYNTHESIS
	a_cnt: assert property (@(posedge clk) disable iff (!arst_n) fcnt_q <= FCNT_BITS'(FREE_SLOTS))
		else $error("free count overflow");
	a_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_APPLY |=> rvalid_q) else $error("missing response");
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		rvalid_q |-> !req.ready) else $error("accept while response pending");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.status)
		&& $stable(rsp.seg_base) && $stable(rsp.seg_len)) else $error("response beat changed");
	`endif
endmodule

@@ hw/rtl/bfsa_free_cell.sv @@
module bfsa_free_cell
	import bfsa_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic [FIDX_BITS-1:0] idx,
	input  fctl_t                ctl,
	input  seg_t                 from_above,
	input  seg_t                 from_below,
	output seg_t                 seg
);
	seg_t seg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seg_q <= '0;
		end else begin
			unique case (ctl.cmd)
				FC_INIT: begin
					seg_q <= (idx == '0 && ctl.init_ok) ? ctl.init : '0;
				end
				FC_SHIFT_DOWN: begin
					// close a gap: cells from pos upwards take the upper neighbour
					if (idx >= ctl.pos) seg_q <= from_above;
				end
				FC_SHIFT_UP: begin
					// open a gap at pos
					if (idx > ctl.pos) seg_q <= from_below;
					else if (idx == ctl.pos) seg_q <= ctl.seg;
				end
				FC_LOAD: begin
					if (idx == ctl.pos) seg_q <= ctl.seg;
				end
				FC_MERGE: begin
					// widen the cell below pos and drop the cell at pos
					if (idx >= ctl.pos) seg_q <= from_above;
					else if (idx == ctl.pos - FIDX_BITS'(1)) seg_q <= ctl.seg;
				end
				default: begin
				end
			endcase
		end
	end

	assign seg = seg_q;
endmodule
